// ===== hdl/qvr_pkg.sv =====
// Package for the quaternion vector rotate pipeline.
// Holds field widths, fixed-point constants and the payload structs.
// No dependencies.
package qvr_pkg;

    // Component width, signed Q16.16 vectors and signed Q2.30 quaternions
    localparam int DATA_WIDTH = 32;
    localparam int QUAT_FRAC  = 30;
    // t = 2*c / 2^QUAT_FRAC folds into one shift
    localparam int T_SHIFT    = QUAT_FRAC - 1;

    // Exact widths of the intermediates
    localparam int PROD_W  = 2 * DATA_WIDTH;
    localparam int CROSS_W = PROD_W + 1;
    localparam int RND_W   = CROSS_W + 1;
    localparam int T_W     = RND_W - T_SHIFT;
    localparam int T_LO_W  = T_W / 2;
    localparam int T_HI_W  = T_W - T_LO_W;
    localparam int SUM_W   = (DATA_WIDTH + T_W + 4 > QUAT_FRAC + 4) ?
                             (DATA_WIDTH + T_W + 4) : (QUAT_FRAC + 4);

    // Pipeline depth, output register included
    localparam int NUM_STAGES = 6;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] vec_x;
        logic signed [DATA_WIDTH-1:0] vec_y;
        logic signed [DATA_WIDTH-1:0] vec_z;
        logic signed [DATA_WIDTH-1:0] quat_w;
        logic signed [DATA_WIDTH-1:0] quat_x;
        logic signed [DATA_WIDTH-1:0] quat_y;
        logic signed [DATA_WIDTH-1:0] quat_z;
    } t_qvr_in;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] rot_x;
        logic signed [DATA_WIDTH-1:0] rot_y;
        logic signed [DATA_WIDTH-1:0] rot_z;
        logic                         saturated;
    } t_qvr_out;

endpackage

// ===== hdl/quaternion_vector_rotate.sv =====
// Quaternion rotation of a 3D vector: v' = v + w*t + q x t, t = 2(q x v).
// Six-stage pipeline with saturating output; uses qvr_pkg.
//
// Usage:
//   Input channel: i_in_valid / o_in_stall carry one t_qvr_in item (vector in
//   signed Q16.16, quaternion in signed Q2.30). A transfer happens at a rising
//   edge with valid high and stall low.
//   Output channel: o_out_valid / i_out_stall carry one t_qvr_out item, the
//   rotated vector in signed Q16.16, each component clipped to the signed
//   32-bit range, and a flag set when any component was clipped.
//   Throughput: one rotation per cycle while i_out_stall is low; the six
//   stages are product of q and v, cross difference and rounding to t, split
//   partial products of w and q with t, partial assembly, rounding and sum,
//   saturation into the output register.
//   Stall: a stalled output holds its item; stages behind it keep filling any
//   empty slot, so o_in_stall rises only when every stage holds an item.
//   Reset: synchronous, active low; clears all stage valid bits, nothing else.
//   No configuration; items are independent of one another.
module quaternion_vector_rotate (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  qvr_pkg::t_qvr_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output qvr_pkg::t_qvr_out o_out_data
);

    localparam int DW     = qvr_pkg::DATA_WIDTH;
    localparam int NSTG   = qvr_pkg::NUM_STAGES;
    localparam int PW     = qvr_pkg::PROD_W;
    localparam int CW     = qvr_pkg::CROSS_W;
    localparam int RW     = qvr_pkg::RND_W;
    localparam int TW     = qvr_pkg::T_W;
    localparam int TLW    = qvr_pkg::T_LO_W;
    localparam int THW    = qvr_pkg::T_HI_W;
    localparam int SW     = qvr_pkg::SUM_W;
    localparam int LO_PW  = DW + TLW + 1;
    localparam int HI_PW  = DW + THW;

    localparam logic signed [RW-1:0] T_HALF = RW'(1) << (qvr_pkg::T_SHIFT - 1);
    localparam logic signed [SW-1:0] R_HALF = SW'(1) << (qvr_pkg::QUAT_FRAC - 1);
    localparam logic signed [SW-1:0] S_MAX  = SW'({1'b0, {(DW-1){1'b1}}});
    localparam logic signed [SW-1:0] S_MIN  = ~S_MAX;

    // Stage valid bits and advance chain
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] adv;

    always_comb begin
        adv[NSTG-1] = !r_vld[NSTG-1] || !i_out_stall;
        for (int s = NSTG - 2; s >= 0; s--) begin
            adv[s] = !r_vld[s] || adv[s+1];
        end
    end

    assign o_in_stall = !adv[0];

    // Advance valid bits, fill bubbles
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[0]) begin
                r_vld[0] <= i_in_valid;
            end
            for (int s = 1; s < NSTG; s++) begin
                if (adv[s]) begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
        end
    end

    // Unpack input components, index 0..2 is x..z
    logic signed [DW-1:0] in_v [3];
    logic signed [DW-1:0] in_q [3];

    assign in_v[0] = i_in_data.vec_x;
    assign in_v[1] = i_in_data.vec_y;
    assign in_v[2] = i_in_data.vec_z;
    assign in_q[0] = i_in_data.quat_x;
    assign in_q[1] = i_in_data.quat_y;
    assign in_q[2] = i_in_data.quat_z;

    // Carried operands
    qvr_pkg::t_qvr_in     r1_in, r2_in;
    logic signed [DW-1:0] r3_v [3];
    logic signed [DW-1:0] r4_v [3];
    logic signed [DW-1:0] r2_q [3];

    assign r2_q[0] = r2_in.quat_x;
    assign r2_q[1] = r2_in.quat_y;
    assign r2_q[2] = r2_in.quat_z;

    // Stage registers
    logic signed [PW-1:0]    r1_pa [3];
    logic signed [PW-1:0]    r1_pb [3];
    logic signed [TW-1:0]    r2_t  [3];
    logic signed [LO_PW-1:0] r3_wl [3];
    logic signed [HI_PW-1:0] r3_wh [3];
    logic signed [LO_PW-1:0] r3_al [3];
    logic signed [HI_PW-1:0] r3_ah [3];
    logic signed [LO_PW-1:0] r3_bl [3];
    logic signed [HI_PW-1:0] r3_bh [3];
    logic signed [SW-1:0]    r4_wt [3];
    logic signed [SW-1:0]    r4_d  [3];
    logic signed [SW-1:0]    r5_s  [3];
    logic signed [DW-1:0]    r6_rot [3];
    logic [2:0]              r6_clip;

    // Hold the carried operands
    always_ff @(posedge i_clk) begin
        if (adv[0]) begin
            r1_in <= i_in_data;
        end
        if (adv[1]) begin
            r2_in <= r1_in;
        end
        if (adv[2]) begin
            r3_v[0] <= r2_in.vec_x;
            r3_v[1] <= r2_in.vec_y;
            r3_v[2] <= r2_in.vec_z;
        end
        if (adv[3]) begin
            r4_v <= r3_v;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_comp
        localparam int K1 = (k + 1) % 3;
        localparam int K2 = (k + 2) % 3;

        logic signed [CW-1:0]    c;
        logic signed [RW-1:0]    c_rnd;
        logic signed [RW-1:0]    t_full;
        logic signed [TLW:0]     t_lo;
        logic signed [THW-1:0]   t_hi;
        logic signed [TLW:0]     t2_lo;
        logic signed [THW-1:0]   t2_hi;
        logic signed [TLW:0]     t1_lo;
        logic signed [THW-1:0]   t1_hi;
        logic signed [SW-1:0]    wt_full;
        logic signed [SW-1:0]    a_full;
        logic signed [SW-1:0]    b_full;
        logic signed [SW-1:0]    a_rnd;
        logic signed [SW-1:0]    b_rnd;
        logic                    over;
        logic                    under;

        // Cross difference of q and v, then round to t
        assign c      = CW'(r1_pa[k]) - CW'(r1_pb[k]);
        assign c_rnd  = RW'(c) + T_HALF;
        assign t_full = c_rnd >>> qvr_pkg::T_SHIFT;

        // Split t into an unsigned low part and a signed high part
        assign t_lo  = $signed({1'b0, r2_t[k][TLW-1:0]});
        assign t_hi  = r2_t[k][TW-1:TLW];
        assign t2_lo = $signed({1'b0, r2_t[K2][TLW-1:0]});
        assign t2_hi = r2_t[K2][TW-1:TLW];
        assign t1_lo = $signed({1'b0, r2_t[K1][TLW-1:0]});
        assign t1_hi = r2_t[K1][TW-1:TLW];

        // Assemble partial products
        assign wt_full = (SW'(r3_wh[k]) <<< TLW) + SW'(r3_wl[k]);
        assign a_full  = (SW'(r3_ah[k]) <<< TLW) + SW'(r3_al[k]);
        assign b_full  = (SW'(r3_bh[k]) <<< TLW) + SW'(r3_bl[k]);

        // Round both terms to Q16.16
        assign a_rnd = (r4_wt[k] + R_HALF) >>> qvr_pkg::QUAT_FRAC;
        assign b_rnd = (r4_d[k] + R_HALF) >>> qvr_pkg::QUAT_FRAC;

        // Clip detection
        assign over  = r5_s[k] > S_MAX;
        assign under = r5_s[k] < S_MIN;

        always_ff @(posedge i_clk) begin
            // Products of q and v
            if (adv[0]) begin
                r1_pa[k] <= in_q[K1] * in_v[K2];
                r1_pb[k] <= in_q[K2] * in_v[K1];
            end
            // Rounded t
            if (adv[1]) begin
                r2_t[k] <= t_full[TW-1:0];
            end
            // Partial products of w*t and q x t
            if (adv[2]) begin
                r3_wl[k] <= r2_in.quat_w * t_lo;
                r3_wh[k] <= r2_in.quat_w * t_hi;
                r3_al[k] <= r2_q[K1] * t2_lo;
                r3_ah[k] <= r2_q[K1] * t2_hi;
                r3_bl[k] <= r2_q[K2] * t1_lo;
                r3_bh[k] <= r2_q[K2] * t1_hi;
            end
            // Full w*t and cross component
            if (adv[3]) begin
                r4_wt[k] <= wt_full;
                r4_d[k]  <= a_full - b_full;
            end
            // Unclipped sum
            if (adv[4]) begin
                r5_s[k] <= SW'(r4_v[k]) + a_rnd + b_rnd;
            end
            // Saturate into the output register
            if (adv[5]) begin
                r6_clip[k] <= over || under;
                if (over) begin
                    r6_rot[k] <= S_MAX[DW-1:0];
                end else if (under) begin
                    r6_rot[k] <= S_MIN[DW-1:0];
                end else begin
                    r6_rot[k] <= r5_s[k][DW-1:0];
                end
            end
        end
    end

    // Drive the output channel
    assign o_out_valid          = r_vld[NSTG-1];
    assign o_out_data.rot_x     = r6_rot[0];
    assign o_out_data.rot_y     = r6_rot[1];
    assign o_out_data.rot_z     = r6_rot[2];
    assign o_out_data.saturated = |r6_clip;

    // Input stalls only when every stage is occupied
    a_stall_full : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (&r_vld))
        else $error("input stalled while a stage is empty");

    // A clipped result has at least one component at a range limit
    a_sat_limit : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.saturated) |->
            (o_out_data.rot_x == S_MAX[DW-1:0] || o_out_data.rot_x == S_MIN[DW-1:0] ||
             o_out_data.rot_y == S_MAX[DW-1:0] || o_out_data.rot_y == S_MIN[DW-1:0] ||
             o_out_data.rot_z == S_MAX[DW-1:0] || o_out_data.rot_z == S_MIN[DW-1:0]))
        else $error("saturated flag without a clipped component");

    // Reset empties the pipeline
    a_rst_empty : assert property (@(posedge i_clk)
        !i_rst_n |=> (r_vld == '0))
        else $error("pipeline not empty after reset");

endmodule

// ===== dv/tb.sv =====
// Self-checking testbench for quaternion_vector_rotate.
// Directed table, then random rotations under random idle on both channels; each result matches
// a typed row value or an exact wide-integer prediction. Depends on hdl/qvr_pkg.sv and the RTL.
module tb;

    localparam int DW    = qvr_pkg::DATA_WIDTH;
    localparam int ACC_W = 128;
    typedef logic signed [ACC_W-1:0] t_acc;

    localparam t_acc SAT_MAX = (t_acc'(1) <<< (DW - 1)) - 1;
    localparam t_acc SAT_MIN = -(t_acc'(1) <<< (DW - 1));

    // Handy operand values: 1.0 in Q2.30 and Q16.16, cos(45 deg) in Q2.30
    localparam logic signed [DW-1:0] ONE_Q = 32'sh4000_0000;
    localparam logic signed [DW-1:0] ONE_V = 32'sh0001_0000;
    localparam logic signed [DW-1:0] COS45 = 32'sd759250125;
    localparam logic signed [DW-1:0] MAXV  = 32'sh7fff_ffff;
    localparam logic signed [DW-1:0] MINV  = 32'sh8000_0000;

    localparam int RAND_ITEMS = 930;
    localparam int TAIL_ITEMS = 120;

    typedef struct {
        qvr_pkg::t_qvr_in  stim;
        bit                typed;
        qvr_pkg::t_qvr_out want;
    } t_stim_row;

    logic              i_clk;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_stall;
    qvr_pkg::t_qvr_in  i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_stall = 1'b0;
    qvr_pkg::t_qvr_out o_out_data;

    // Expectation that travels with the current input when the table gives one
    logic              row_typed = 1'b0;
    qvr_pkg::t_qvr_out row_want  = '0;

    bit                quiet_tail = 1'b0;
    qvr_pkg::t_qvr_out rot_q[$];
    t_stim_row         dir_rows[$];
    int                err_cnt     = 0;
    int                checked_cnt = 0;
    int                sat_cnt     = 0;

    quaternion_vector_rotate dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3000000;
        $display("tb NOT OK");
        $finish;
    end

    function automatic t_acc widen(logic [DW-1:0] x);
        return {{(ACC_W-DW){x[DW-1]}}, x};
    endfunction

    // Add half an LSB, then shift arithmetically
    function automatic t_acc round_shift(t_acc x, int n);
        return (x + (t_acc'(1) <<< (n - 1))) >>> n;
    endfunction

    // Exact rotation: t = 2(q x v), v' = v + w*t + q x t, then clip each component
    function automatic qvr_pkg::t_qvr_out rotate_vector(qvr_pkg::t_qvr_in d);
        t_acc              v[3];
        t_acc              q[3];
        t_acc              c[3];
        t_acc              t[3];
        t_acc              qt[3];
        t_acc              w;
        t_acc              r;
        logic [DW-1:0]     comp[3];
        qvr_pkg::t_qvr_out res;
        int                k;
        v[0] = widen(d.vec_x);
        v[1] = widen(d.vec_y);
        v[2] = widen(d.vec_z);
        q[0] = widen(d.quat_x);
        q[1] = widen(d.quat_y);
        q[2] = widen(d.quat_z);
        w    = widen(d.quat_w);
        c[0] = q[1] * v[2] - q[2] * v[1];
        c[1] = q[2] * v[0] - q[0] * v[2];
        c[2] = q[0] * v[1] - q[1] * v[0];
        for (k = 0; k < 3; k++) t[k] = round_shift(c[k], qvr_pkg::T_SHIFT);
        qt[0] = q[1] * t[2] - q[2] * t[1];
        qt[1] = q[2] * t[0] - q[0] * t[2];
        qt[2] = q[0] * t[1] - q[1] * t[0];
        res = '0;
        for (k = 0; k < 3; k++) begin
            r = v[k] + round_shift(w * t[k], qvr_pkg::QUAT_FRAC)
                + round_shift(qt[k], qvr_pkg::QUAT_FRAC);
            if (r > SAT_MAX) begin
                r = SAT_MAX;
                res.saturated = 1'b1;
            end else if (r < SAT_MIN) begin
                r = SAT_MIN;
                res.saturated = 1'b1;
            end
            comp[k] = r[DW-1:0];
        end
        res.rot_x = comp[0];
        res.rot_y = comp[1];
        res.rot_z = comp[2];
        return res;
    endfunction

    function automatic qvr_pkg::t_qvr_in mk_in(logic [DW-1:0] vx, logic [DW-1:0] vy,
                                               logic [DW-1:0] vz, logic [DW-1:0] qw,
                                               logic [DW-1:0] qx, logic [DW-1:0] qy,
                                               logic [DW-1:0] qz);
        return '{vx, vy, vz, qw, qx, qy, qz};
    endfunction

    function automatic qvr_pkg::t_qvr_out mk_out(logic [DW-1:0] rx, logic [DW-1:0] ry,
                                                 logic [DW-1:0] rz, logic sat);
        return '{rx, ry, rz, sat};
    endfunction

    function automatic logic [DW-1:0] pick_extreme();
        case ($urandom_range(0, 5))
            0:       return MAXV;
            1:       return MINV;
            2:       return '0;
            3:       return '1;
            4:       return 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly rotation-like operands; the rest raw bits, exact axis turns and extremes
    function automatic qvr_pkg::t_qvr_in random_rotation();
        qvr_pkg::t_qvr_in d;
        int unsigned      mode;
        logic [DW-1:0]    ax;
        int unsigned      axis;
        mode = $urandom_range(0, 9);
        if (mode <= 1) begin
            d = mk_in($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        end else if (mode <= 7) begin
            d.vec_x  = $urandom_range(0, 1 << 25) - (1 << 24);
            d.vec_y  = $urandom_range(0, 1 << 25) - (1 << 24);
            d.vec_z  = $urandom_range(0, 1 << 25) - (1 << 24);
            d.quat_w = $urandom_range(0, 1 << 30) - (1 << 29);
            d.quat_x = $urandom_range(0, 1 << 30) - (1 << 29);
            d.quat_y = $urandom_range(0, 1 << 30) - (1 << 29);
            d.quat_z = $urandom_range(0, 1 << 30) - (1 << 29);
        end else if (mode == 8) begin
            d = mk_in($urandom, $urandom, $urandom, '0, '0, '0, '0);
            case ($urandom_range(0, 3))
                0: begin d.quat_w = '0;     ax = $urandom_range(0, 1) ? ONE_Q : -ONE_Q; end
                1: begin d.quat_w = ONE_Q;  ax = '0; end
                2: begin d.quat_w = COS45;  ax = $urandom_range(0, 1) ? COS45 : -COS45; end
                default: begin
                    d.quat_w = -COS45;
                    ax = $urandom_range(0, 1) ? COS45 : -COS45;
                end
            endcase
            axis = $urandom_range(0, 2);
            if (axis == 0) d.quat_x = ax;
            else if (axis == 1) d.quat_y = ax;
            else d.quat_z = ax;
        end else begin
            d = mk_in(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                      pick_extreme(), pick_extreme(), pick_extreme());
        end
        return d;
    endfunction

    function automatic int unsigned idle_len(int unsigned rate);
        if (rate == 0) return 0;
        if ($urandom_range(0, (rate == 1) ? 5 : 1) != 0) return 0;
        return $urandom_range(1, 15);
    endfunction

    task automatic report_error(string msg);
        $display("ERROR: %s", msg);
        err_cnt++;
    endtask

    task automatic compare_field(string name, logic signed [DW-1:0] got,
                                 logic signed [DW-1:0] want);
        if (got !== want)
            report_error($sformatf("result %0d %s: got %0d want %0d",
                                   checked_cnt, name, got, want));
    endtask

    // Offer one item and hold it until the transfer happens
    task automatic send_rotation(qvr_pkg::t_qvr_in d, bit typed, qvr_pkg::t_qvr_out want);
        i_in_valid <= 1'b1;
        i_in_data  <= d;
        row_typed  <= typed;
        row_want   <= want;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic hold_off(int unsigned n);
        if (n != 0) begin
            i_in_valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (rot_q.size() != 0) @(posedge i_clk);
    endtask

    // Predict on every input transfer, check on every output transfer
    always @(posedge i_clk) begin : check_results
        qvr_pkg::t_qvr_out want;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall)
                rot_q.push_back(row_typed ? row_want : rotate_vector(i_in_data));
            if (o_out_valid && !i_out_stall) begin
                if (rot_q.size() == 0) begin
                    report_error($sformatf("unexpected result %h", o_out_data));
                end else begin
                    want = rot_q.pop_front();
                    compare_field("rot_x", o_out_data.rot_x, want.rot_x);
                    compare_field("rot_y", o_out_data.rot_y, want.rot_y);
                    compare_field("rot_z", o_out_data.rot_z, want.rot_z);
                    compare_field("saturated", DW'(o_out_data.saturated), DW'(want.saturated));
                    if (want.saturated) sat_cnt++;
                end
                checked_cnt++;
            end
        end
    end

    // Stall the result side in bursts, with longer free stretches between
    initial begin : drive_out_stall
        int unsigned n;
        @(posedge i_clk);
        forever begin
            if (quiet_tail) begin
                i_out_stall <= 1'b0;
                @(posedge i_clk);
            end else if ($urandom_range(0, 2) == 0) begin
                i_out_stall <= 1'b1;
                n = $urandom_range(1, 15);
                repeat (n) @(posedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                n = $urandom_range(1, 40);
                repeat (n) @(posedge i_clk);
            end
        end
    end

    initial begin : drive_inputs
        int unsigned idle_rate;
        int          n;
        // Table: typed results where they follow at a glance, others predicted
        dir_rows.push_back('{mk_in(0, 0, 0, 0, 0, 0, 0), 1'b1, mk_out(0, 0, 0, 1'b0)});
        dir_rows.push_back('{mk_in(MAXV, MINV, 1, ONE_Q, 0, 0, 0), 1'b1,
                             mk_out(MAXV, MINV, 1, 1'b0)});
        dir_rows.push_back('{mk_in(MINV, MAXV, -1, MINV, 0, 0, 0), 1'b1,
                             mk_out(MINV, MAXV, -1, 1'b0)});
        dir_rows.push_back('{mk_in(ONE_V, 0, 0, 0, 0, 0, ONE_Q), 1'b1,
                             mk_out(-ONE_V, 0, 0, 1'b0)});
        dir_rows.push_back('{mk_in(MINV, 0, 0, 0, 0, 0, ONE_Q), 1'b1,
                             mk_out(MAXV, 0, 0, 1'b1)});
        dir_rows.push_back('{mk_in(0, MINV, 5, 0, 0, 0, ONE_Q), 1'b1,
                             mk_out(0, MAXV, 5, 1'b1)});
        dir_rows.push_back('{mk_in(ONE_V, 2 * ONE_V, 3 * ONE_V, 0, ONE_Q, 0, 0), 1'b1,
                             mk_out(ONE_V, -2 * ONE_V, -3 * ONE_V, 1'b0)});
        dir_rows.push_back('{mk_in(MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV), 1'b0, '0});
        dir_rows.push_back('{mk_in(MINV, MINV, MINV, MINV, MINV, MINV, MINV), 1'b0, '0});
        dir_rows.push_back('{mk_in(MAXV, MINV, MAXV, MINV, MAXV, MINV, MAXV), 1'b0, '0});
        dir_rows.push_back('{mk_in(ONE_V, 0, 0, COS45, 0, 0, COS45), 1'b0, '0});
        dir_rows.push_back('{mk_in(0, ONE_V, ONE_V, COS45, COS45, 0, 0), 1'b0, '0});
        dir_rows.push_back('{mk_in(7 * ONE_V, -3, 12345, COS45, 0, COS45, 0), 1'b0, '0});
        // Non-unit quaternion, but q is parallel to v, so t is zero and the result is v
        dir_rows.push_back('{mk_in(ONE_V, ONE_V, ONE_V, ONE_Q, ONE_Q, ONE_Q, ONE_Q), 1'b0, '0});
        dir_rows.push_back('{mk_in(MAXV, MAXV, MINV, -ONE_Q, MINV, MINV, MINV), 1'b0, '0});
        dir_rows.push_back('{mk_in(1, -1, 1, 1, -1, 1, -1), 1'b0, '0});
        dir_rows.push_back('{mk_in(-1, -1, -1, -1, MINV, MAXV, 1), 1'b0, '0});
        dir_rows.push_back('{mk_in(-1, -1, -1, -1, -1, -1, -1), 1'b0, '0});

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            send_rotation(dir_rows[i].stim, dir_rows[i].typed, dir_rows[i].want);
            hold_off(idle_len(1));
        end
        wait_drained();

        idle_rate = 1;
        for (n = 0; n < RAND_ITEMS; n++) begin
            if (n % 64 == 0) idle_rate = $urandom_range(0, 2);
            // Hold the sender once mid-run until the pipeline is empty
            if (n == RAND_ITEMS / 2) wait_drained();
            if (n == RAND_ITEMS - TAIL_ITEMS) quiet_tail = 1'b1;
            send_rotation(random_rotation(), 1'b0, '0);
            if (!quiet_tail) hold_off(idle_len(idle_rate));
        end

        wait_drained();
        repeat (2 * qvr_pkg::NUM_STAGES + 4) @(posedge i_clk);

        $display("Covered %0d table rows and %0d random rotations, with idle on both channels.",
                 dir_rows.size(), RAND_ITEMS);
        $display("Checked %0d results, %0d of them clipped.", checked_cnt, sat_cnt);
        if (err_cnt == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end

endmodule
